// File: src/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared widths, register indexes and the control/status bundles for the
// hypercube probe enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package hpe_pkg;

  // Cube size and probe budget.
  localparam int MAX_BITS   = 16;
  localparam int MAX_PROBES = 64;

  // Field widths.
  localparam int BUCKET_W   = 16;
  localparam int FLIP_W     = 5;
  localparam int K_W        = 5;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Internal widths derived from the sizes above.
  localparam int POS_W = $clog2(MAX_BITS);
  localparam int SUM_W = $clog2(MAX_BITS) + 2;
  localparam int CNT_W = $clog2(MAX_PROBES + 1);

  // Register reset values.
  localparam logic [K_W-1:0]     K_RESET     = K_W'(8);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BUCKET_BITS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PROBE_LIMIT = cfg_idx_t'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

// File: src/hpe_ctrl.sv
// ----------------------------------------------------------------------------
// hpe_ctrl
// Controller: waits for a query item, then steps the datapath one probe per
// free output slot until the final probe of the query has been issued.
// ----------------------------------------------------------------------------
`default_nettype none

module hpe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output hpe_pkg::cmd_t        cmd,
  input  wire hpe_pkg::status_t status
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode.
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.emit = (state == ST_RUN) && status.slot_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.emit && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

`ifndef NO_ASSERTIONS
  // Issuing the final probe frees the input for the next query.
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.last |=> in_ready)
    else $error("input not ready after final probe");

  // No probe is issued while a new query can be taken.
  a_no_emit_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.emit)
    else $error("probe issued while idle");
`endif

endmodule

`default_nettype wire

// File: src/hpe_dpath.sv
// ----------------------------------------------------------------------------
// hpe_dpath
// Datapath: configuration registers, the current flip-position set, the probe
// counter and the output register. Each emit steps the position set to the
// next combination in lexicographic order, or to the first set of the next
// distance.
// ----------------------------------------------------------------------------
`default_nettype none

module hpe_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [hpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [hpe_pkg::BUCKET_W-1:0]    base_bucket,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [hpe_pkg::BUCKET_W-1:0]         probe_bucket,
  output logic [hpe_pkg::FLIP_W-1:0]           flip_count,
  output logic                                 last_probe,
  input  wire hpe_pkg::cmd_t                   cmd,
  output hpe_pkg::status_t                     status
);

  // Configuration registers.
  logic [hpe_pkg::K_W-1:0]     bucket_bits;
  logic [hpe_pkg::LIMIT_W-1:0] probe_limit;

  // Per-query state.
  logic [hpe_pkg::BUCKET_W-1:0] base;
  logic [hpe_pkg::K_W-1:0]      k;
  logic [hpe_pkg::CNT_W-1:0]    total;
  logic [hpe_pkg::CNT_W-1:0]    count;
  logic [hpe_pkg::FLIP_W-1:0]   d;
  logic [hpe_pkg::POS_W-1:0]    pos [hpe_pkg::MAX_BITS];

  // Next values and load-time values.
  logic [hpe_pkg::FLIP_W-1:0]   d_next;
  logic [hpe_pkg::POS_W-1:0]    pos_next [hpe_pkg::MAX_BITS];
  logic [hpe_pkg::K_W-1:0]      k_sat;
  logic [hpe_pkg::CNT_W-1:0]    limit_sat;
  logic [hpe_pkg::CNT_W-1:0]    total_load;
  logic [hpe_pkg::BUCKET_W-1:0] base_mask;
  logic [hpe_pkg::MAX_BITS-1:0] flip_mask;

  // Clamp the registers into range and size the query.
  always_comb begin
    logic [hpe_pkg::CNT_W-1:0] cube;
    k_sat = bucket_bits;
    if (bucket_bits == '0) begin
      k_sat = hpe_pkg::K_W'(1);
    end else if (bucket_bits > hpe_pkg::K_W'(hpe_pkg::MAX_BITS)) begin
      k_sat = hpe_pkg::K_W'(hpe_pkg::MAX_BITS);
    end
    limit_sat = hpe_pkg::CNT_W'(probe_limit);
    if (probe_limit == '0) begin
      limit_sat = hpe_pkg::CNT_W'(1);
    end else if (probe_limit > hpe_pkg::LIMIT_W'(hpe_pkg::MAX_PROBES)) begin
      limit_sat = hpe_pkg::CNT_W'(hpe_pkg::MAX_PROBES);
    end
    // A cube smaller than the budget caps the probe count.
    cube       = hpe_pkg::CNT_W'(1) << k_sat;
    total_load = limit_sat;
    if (k_sat < hpe_pkg::K_W'(hpe_pkg::CNT_W) && cube < limit_sat) begin
      total_load = cube;
    end
    base_mask = ~({hpe_pkg::BUCKET_W{1'b1}} << k_sat);
  end

  // Bit mask of the current flip-position set.
  always_comb begin
    flip_mask = '0;
    for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
      if (hpe_pkg::SUM_W'(i) < hpe_pkg::SUM_W'(d)) begin
        flip_mask[pos[i]] = 1'b1;
      end
    end
  end

  // Step to the next combination. An entry is packed when it already sits
  // at its highest possible place; the packed entries form a suffix, and the
  // entry just below that suffix is the one to advance.
  always_comb begin
    logic [hpe_pkg::MAX_BITS:0]   packed_q;
    logic [hpe_pkg::MAX_BITS-1:0] j_hot;
    logic [hpe_pkg::POS_W-1:0]    j_idx;
    logic [hpe_pkg::POS_W-1:0]    pos_j;
    logic                         any_j;
    for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
      if (hpe_pkg::SUM_W'(i) >= hpe_pkg::SUM_W'(d)) begin
        packed_q[i] = 1'b1;
      end else begin
        packed_q[i] = (hpe_pkg::SUM_W'(pos[i]) + hpe_pkg::SUM_W'(d)) >=
                      (hpe_pkg::SUM_W'(k) + hpe_pkg::SUM_W'(i));
      end
    end
    packed_q[hpe_pkg::MAX_BITS] = 1'b1;
    j_idx = '0;
    pos_j = '0;
    for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
      j_hot[i] = !packed_q[i] && packed_q[i+1];
      if (j_hot[i]) begin
        j_idx = j_idx | hpe_pkg::POS_W'(i);
        pos_j = pos_j | pos[i];
      end
    end
    any_j = |j_hot;
    for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
      if (!any_j) begin
        pos_next[i] = hpe_pkg::POS_W'(i);
      end else if (hpe_pkg::SUM_W'(i) < hpe_pkg::SUM_W'(j_idx)) begin
        pos_next[i] = pos[i];
      end else begin
        pos_next[i] = hpe_pkg::POS_W'(hpe_pkg::SUM_W'(pos_j) + hpe_pkg::SUM_W'(1) +
                                      hpe_pkg::SUM_W'(i) - hpe_pkg::SUM_W'(j_idx));
      end
    end
    d_next = any_j ? d : d + hpe_pkg::FLIP_W'(1);
  end

  // Status toward the controller.
  always_comb begin
    status.last      = (count + hpe_pkg::CNT_W'(1)) == total;
    status.slot_free = !out_valid || out_ready;
  end

  // Control registers: configuration, counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_bits <= hpe_pkg::K_RESET;
      probe_limit <= hpe_pkg::LIMIT_RESET;
      count       <= '0;
      total       <= hpe_pkg::CNT_W'(1);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          hpe_pkg::CFG_BUCKET_BITS: bucket_bits <= cfg_data[hpe_pkg::K_W-1:0];
          hpe_pkg::CFG_PROBE_LIMIT: probe_limit <= cfg_data[hpe_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        count <= '0;
        total <= total_load;
      end else if (cmd.emit) begin
        count <= count + hpe_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: query, position set and output item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= base_bucket & base_mask;
      k    <= k_sat;
      d    <= '0;
      for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
        pos[i] <= hpe_pkg::POS_W'(i);
      end
    end else if (cmd.emit) begin
      d <= d_next;
      for (int i = 0; i < hpe_pkg::MAX_BITS; i++) begin
        pos[i] <= pos_next[i];
      end
    end
    if (cmd.emit) begin
      probe_bucket <= base ^ hpe_pkg::BUCKET_W'(flip_mask);
      flip_count   <= d;
      last_probe   <= status.last;
    end
  end

`ifndef NO_ASSERTIONS
  // The probe counter never passes the query's total.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= total)
    else $error("probe count beyond total");

  // Every issued probe flips exactly as many bits as its distance.
  a_flip_weight: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $countones(flip_mask) == int'(d))
    else $error("flip mask weight differs from distance");

  // The final probe of a query leaves the counter at the total.
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.last |=> count == total && last_probe)
    else $error("final probe did not close the query");
`endif

endmodule

`default_nettype wire

// File: src/hypercube_probe_enumerator_unit.sv
// ----------------------------------------------------------------------------
// hypercube_probe_enumerator_unit
// Lists the hypercube buckets to probe for one query bucket: the bucket
// itself, then the buckets at Hamming distance 1, 2 and so on, up to the probe limit.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    base_bucket
//   out      output     out_valid / out_ready  probe_bucket, flip_count,
//                                              last_probe
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A query is loaded when taken, then yields one probe per cycle while output
// is not stalled, min(probe_limit, 2^bucket_bits) probes in all (limit clamped
// to 1..64, bits to 1..16), paced by the single combination-step unit.
// The next query item is taken the cycle after its predecessor's final probe
// enters the output register. Output stalls hold the stepping in place.
// Reset is synchronous and returns both registers to 8; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hypercube_probe_enumerator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [hpe_pkg::BUCKET_W-1:0]    base_bucket,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [hpe_pkg::BUCKET_W-1:0]         probe_bucket,
  output logic [hpe_pkg::FLIP_W-1:0]           flip_count,
  output logic                                 last_probe,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hpe_pkg::cmd_t    cmd;
  hpe_pkg::status_t status;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencing.
  hpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Enumeration and output register.
  hpe_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .base_bucket  (base_bucket),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .probe_bucket (probe_bucket),
    .flip_count   (flip_count),
    .last_probe   (last_probe),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire

// File: tb/hypercube_probe_enumerator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_probe_enumerator_unit_test
// Self-checking bench for the hypercube probe enumerator. Query items go in
// over the input channel, the register file is set over the cfg channel
// while the block is idle, and every probe that comes out is checked field
// by field against a list that is built here from the same enumeration
// rules. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------

module hypercube_probe_enumerator_unit_test;

  // Register indexes beyond the list; writes to them change nothing.
  localparam hpe_pkg::cfg_idx_t CFG_SPARE_2 = hpe_pkg::cfg_idx_t'(2);
  localparam hpe_pkg::cfg_idx_t CFG_SPARE_3 = hpe_pkg::cfg_idx_t'(3);

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [hpe_pkg::BUCKET_W-1:0] bucket;
    logic [hpe_pkg::FLIP_W-1:0]   flips;
    logic                         last;
  } probe_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [hpe_pkg::BUCKET_W-1:0]       base_bucket = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [hpe_pkg::BUCKET_W-1:0]       probe_bucket;
  logic [hpe_pkg::FLIP_W-1:0]         flip_count;
  logic                               last_probe;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  hpe_pkg::cfg_idx_t                  cfg_index = hpe_pkg::CFG_BUCKET_BITS;
  logic [hpe_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Register copies used for the expected probe lists.
  logic [hpe_pkg::K_W-1:0]            k_shadow = hpe_pkg::K_RESET;
  logic [hpe_pkg::LIMIT_W-1:0]        limit_shadow = hpe_pkg::LIMIT_RESET;

  probe_t                             pending_probes[$];
  int                                 fail_count = 0;
  int                                 quiet_cycles = 0;
  int                                 stall_left = 0;
  bit                                 idle_on = 1'b1;

  hypercube_probe_enumerator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .base_bucket  (base_bucket),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .probe_bucket (probe_bucket),
    .flip_count   (flip_count),
    .last_probe   (last_probe),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Append one expected probe at the tail of the list.
  task automatic queue_probe(input probe_t entry);
    pending_probes = {pending_probes, entry};
  endtask

  // Build the probe list of one query: the base, then every flip set of
  // size 1, 2 and so on, each size in lexicographic order of its bit indices.
  task automatic predict_probes(input logic [hpe_pkg::BUCKET_W-1:0] query);
    int k;
    int limit;
    int total;
    int n;
    int d;
    int i;
    int j;
    int sel[hpe_pkg::MAX_BITS];
    bit done;
    logic [31:0] mask;
    logic [hpe_pkg::BUCKET_W-1:0] base;
    logic [hpe_pkg::BUCKET_W-1:0] flip;
    k = int'(k_shadow);
    limit = int'(limit_shadow);
    if (k < 1) k = 1;
    if (k > hpe_pkg::MAX_BITS) k = hpe_pkg::MAX_BITS;
    if (limit < 1) limit = 1;
    if (limit > hpe_pkg::MAX_PROBES) limit = hpe_pkg::MAX_PROBES;
    total = ((1 << k) < limit) ? (1 << k) : limit;
    mask = (32'd1 << k) - 32'd1;
    base = query & mask[hpe_pkg::BUCKET_W-1:0];
    queue_probe('{base, hpe_pkg::FLIP_W'(0), total == 1});
    n = 1;
    for (d = 1; d <= k && n < total; d++) begin
      for (i = 0; i < d; i++) sel[i] = i;
      done = 1'b0;
      while (!done && n < total) begin
        flip = '0;
        for (i = 0; i < d; i++) flip[sel[i]] = 1'b1;
        queue_probe('{base ^ flip, hpe_pkg::FLIP_W'(d), n + 1 == total});
        n++;
        // Step to the next index set of this size.
        j = d - 1;
        while (j >= 0 && sel[j] >= k - d + j) j--;
        if (j < 0) begin
          done = 1'b1;
        end else begin
          sel[j]++;
          for (i = j + 1; i < d; i++) sel[i] = sel[i-1] + 1;
        end
      end
    end
  endtask

  // Send one query item, at times after a random gap when idling is on.
  task automatic send_query(input logic [hpe_pkg::BUCKET_W-1:0] query);
    cfg_valid <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    base_bucket <= query;
    do @(posedge clk); while (!in_ready);
    predict_probes(query);
  endtask

  // Hold off the sender until every expected probe has come out.
  task automatic drain_probes();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_probes.size() != 0) @(posedge clk);
  endtask

  // One register write. The channel stays valid so that back-to-back writes
  // keep it high; the next item or drain drops it.
  task automatic write_reg(input hpe_pkg::cfg_idx_t idx,
                           input logic [hpe_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hpe_pkg::CFG_BUCKET_BITS: k_shadow = data[hpe_pkg::K_W-1:0];
      hpe_pkg::CFG_PROBE_LIMIT: limit_shadow = data[hpe_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Let the block go idle, then set both registers.
  task automatic configure(input logic [hpe_pkg::CFG_DATA_W-1:0] bits_data,
                           input logic [hpe_pkg::CFG_DATA_W-1:0] limit_data);
    drain_probes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(hpe_pkg::CFG_BUCKET_BITS, bits_data);
    write_reg(hpe_pkg::CFG_PROBE_LIMIT, limit_data);
  endtask

  // Queries under the register values left by reset; high input bits ignored.
  task automatic test_reset_config();
    send_query(16'h0000);
    send_query(16'hFFFF);
    send_query(16'h12A5);
  endtask

  // Smallest and largest cube, including out-of-range dimension counts.
  task automatic test_cube_size_extremes();
    configure(7'd1, 7'd64);
    send_query(16'h0001);
    configure(7'd0, 7'd64);
    send_query(16'hFFFE);
    configure(7'd16, 7'd64);
    send_query(16'hFFFF);
    send_query(16'h0000);
    configure(7'h7F, 7'd64);
    send_query(16'hA5A5);
    configure(7'h68, 7'd64);
    send_query(16'h00FF);
  endtask

  // Probe limits at and beyond both ends, and limits past the cube size.
  task automatic test_limit_extremes();
    configure(7'd4, 7'd0);
    send_query(16'h000F);
    configure(7'd4, 7'd1);
    send_query(16'h0003);
    configure(7'd4, 7'h7F);
    send_query(16'h0009);
    configure(7'd6, 7'd64);
    send_query(16'h002A);
    configure(7'd3, 7'd100);
    send_query(16'h0005);
    configure(7'd16, 7'd63);
    send_query(16'h8001);
  endtask

  // Writes to spare indexes must leave the registers alone.
  task automatic test_spare_index();
    configure(7'd5, 7'd20);
    write_reg(CFG_SPARE_2, 7'h7F);
    write_reg(CFG_SPARE_3, 7'h00);
    send_query(16'h1234);
    drain_probes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SPARE_3, 7'h55);
    write_reg(CFG_SPARE_2, 7'h2A);
    send_query(16'hC3C3);
  endtask

  // Random queries in phases, each phase with its own register values.
  task automatic test_random_queries();
    int phase;
    int i;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(7'd16, 7'd64);
        1: configure(7'd1, 7'd1);
        2: configure(7'($urandom_range(1, 5)), 7'($urandom_range(0, 127)));
        default: configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      endcase
      if ($urandom_range(0, 1) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                  7'($urandom_range(0, 127)));
      // Stretches without idling, and none at all in the last phase.
      idle_on = (phase != 7) && (phase % 3 != 2);
      for (i = 0; i < 38; i++) begin
        if (phase == 3 && i == 19) drain_probes();
        send_query(16'($urandom));
      end
    end
  endtask

  // Receiver side: ready drops in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted probe with the oldest expected one.
  always @(posedge clk) begin : check_probes
    probe_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_probes.size() == 0) begin
        $error("probe with none expected: bucket %0h flips %0d last %0b",
               probe_bucket, flip_count, last_probe);
        fail_count++;
      end else begin
        want = pending_probes.pop_front();
        if (probe_bucket !== want.bucket) begin
          $error("probe_bucket: expected %0h, got %0h", want.bucket, probe_bucket);
          fail_count++;
        end
        if (flip_count !== want.flips) begin
          $error("flip_count: expected %0d, got %0d", want.flips, flip_count);
          fail_count++;
        end
        if (last_probe !== want.last) begin
          $error("last_probe: expected %0b, got %0b", want.last, last_probe);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no item moved for %0d cycles, %0d probes outstanding",
             quiet_cycles, pending_probes.size());
      $display("hypercube_probe_enumerator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_cube_size_extremes();
    test_limit_extremes();
    test_spare_index();
    test_random_queries();
    drain_probes();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("hypercube_probe_enumerator_unit regression: pass");
    end else begin
      $display("hypercube_probe_enumerator_unit regression: fail");
    end
    $finish;
  end

endmodule
